// ===== rtl/black_border_bounds_finder_unit_assert.svh =====
// Assertion macros used by the checker file of the bounds finder.
`ifndef BLACK_BORDER_BOUNDS_FINDER_UNIT_ASSERT_SVH
`define BLACK_BORDER_BOUNDS_FINDER_UNIT_ASSERT_SVH

// Property checked on every rising clock edge while reset is released.
`define BBF_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define BBF_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bbf_pkg.sv =====
`timescale 1ns / 1ps

package bbf_pkg;

    // Field widths of the configuration and the result.
    localparam int SIZE_W  = 12;
    localparam int THR_W   = 8;
    localparam int PCT_W   = 7;
    localparam int COUNT_W = 12;
    // Width of count*100 and percent*size products.
    localparam int PROD_W  = 20;
    localparam int CFG_IDX_W = 3;

    localparam logic [PROD_W-1:0] PCT_SCALE = 20'd100;

    typedef logic [SIZE_W-1:0]    t_size;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [PCT_W-1:0]     t_pct;
    typedef logic [THR_W-1:0]     t_thr;
    typedef logic [PROD_W-1:0]    t_prod;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_IMAGE_WIDTH    = 3'd0;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT   = 3'd1;
    localparam t_cfg_idx CFG_DARK_THRESHOLD = 3'd2;
    localparam t_cfg_idx CFG_TOP_PERCENT    = 3'd3;
    localparam t_cfg_idx CFG_BOTTOM_PERCENT = 3'd4;
    localparam t_cfg_idx CFG_SIDE_PERCENT   = 3'd5;

    // Reset values of the configuration registers.
    localparam t_size RST_WIDTH      = 12'd640;
    localparam t_size RST_HEIGHT     = 12'd480;
    localparam t_thr  RST_THRESHOLD  = 8'd10;
    localparam t_pct  RST_TOP_PCT    = 7'd65;
    localparam t_pct  RST_BOTTOM_PCT = 7'd85;
    localparam t_pct  RST_SIDE_PCT   = 7'd80;

endpackage

// ===== rtl/bbf_if.sv =====
`timescale 1ns / 1ps

// Pixel request channel.
interface bbf_pix_if;
    logic               valid;
    logic               ready;
    bbf_pkg::t_thr      gray_pixel;

    modport source (output valid, output gray_pixel, input ready);
    modport sink   (input valid, input gray_pixel, output ready);
endinterface

// Bounds result channel.
interface bbf_bounds_if;
    logic               valid;
    logic               ready;
    bbf_pkg::t_size     top_row;
    bbf_pkg::t_size     bottom_row;
    bbf_pkg::t_size     left_col;
    bbf_pkg::t_size     right_col;
    logic               all_black;

    modport source (output valid, output top_row, output bottom_row, output left_col,
                    output right_col, output all_black, input ready);
    modport sink   (input valid, input top_row, input bottom_row, input left_col,
                    input right_col, input all_black, output ready);
endinterface

// ===== rtl/black_border_bounds_finder_unit.sv =====
`timescale 1ns / 1ps
// Black border bounds finder.
// i_pix carries one 8-bit gray pixel per request, in raster order. After the
// last pixel of a frame (image_width x image_height, clamped to 1..MAX) one
// request leaves on o_bounds with the top, bottom, left and right bounds and
// the all-black flag; no other pixel produces a result.
// Throughput is one pixel per clock unless a stalled result holds the count
// stage. The pixel path is two stages: the input stage issues the read of the
// column count memory, the count stage adds the hit, writes the count back and
// updates the bounds; the result of the last pixel is then registered on o_bounds.
// Back-to-back accesses to the same column (width of one) use a write-back bypass.
// The configuration port writes one register per cycle with i_cfg_we. The user
// must write it only while no pixel is in flight; the block does not enforce this.
// Reset returns the registers to their defaults, empties the pipeline and the
// result register and points to the first pixel of a frame. The column count
// memory is not cleared: the first row of every frame overwrites it.
// While the receiver stalls, the result is held and pixels keep flowing until
// the last pixel of the next frame reaches the count stage, which then waits.
module black_border_bounds_finder_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  bbf_pkg::t_cfg_idx        i_cfg_idx,
    input  bbf_pkg::t_size           i_cfg_data,
    bbf_pix_if.sink                  i_pix,
    bbf_bounds_if.source             o_bounds
);

    localparam int IW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam bbf_pkg::t_size MAXW_C = (MAX_WIDTH > 4095)  ? 12'd4095 : 12'(MAX_WIDTH);
    localparam bbf_pkg::t_size MAXH_C = (MAX_HEIGHT > 4095) ? 12'd4095 : 12'(MAX_HEIGHT);

    // Configuration registers.
    bbf_pkg::t_size r_width, r_height;
    bbf_pkg::t_thr  r_thr;
    bbf_pkg::t_pct  r_top_pct, r_bot_pct, r_side_pct;

    // Derived thresholds (percent * size).
    bbf_pkg::t_prod r_top_need, r_bot_need, r_side_need;

    // Position and row accumulation.
    logic [IW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    bbf_pkg::t_count r_row_hits;

    // Count stage.
    logic            r_s1_v;
    logic            r_s1_hit;
    logic [IW-1:0]   r_s1_col;
    logic [RW-1:0]   r_s1_row;
    logic            r_s1_first_row;
    logic            r_s1_fstart;
    logic            r_s1_last_col;
    logic            r_s1_last_row;
    bbf_pkg::t_count r_s1_row_hits;
    bbf_pkg::t_count r_rd;

    // Column count memory and write-back bypass.
    bbf_pkg::t_count mem_cols [MAX_WIDTH];
    logic            r_wr_v;
    logic [IW-1:0]   r_wr_col;
    bbf_pkg::t_count r_wr_data;

    // Frame bound state.
    bbf_pkg::t_size r_top, r_bot, r_left, r_right;
    logic           r_top_found, r_left_found;
    bbf_pkg::t_size n_top, n_bot, n_left, n_right;
    logic           n_top_found, n_left_found;

    // Result register.
    logic           r_out_v;
    bbf_pkg::t_size r_out_top, r_out_bot, r_out_left, r_out_right;

    bbf_pkg::t_size  w_c, h_c;
    logic            accept, s1_done, pix_hit, last_col, last_row;
    bbf_pkg::t_count hits_now, prev_cnt, cnt;
    logic            side_ok, top_ok, bot_ok;

    // Sizes clamped to the supported range.
    always_comb begin
        priority if (r_width == '0) begin
            w_c = 12'd1;
        end else if (r_width > MAXW_C) begin
            w_c = MAXW_C;
        end else begin
            w_c = r_width;
        end
        priority if (r_height == '0) begin
            h_c = 12'd1;
        end else if (r_height > MAXH_C) begin
            h_c = MAXH_C;
        end else begin
            h_c = r_height;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= bbf_pkg::RST_WIDTH;
            r_height   <= bbf_pkg::RST_HEIGHT;
            r_thr      <= bbf_pkg::RST_THRESHOLD;
            r_top_pct  <= bbf_pkg::RST_TOP_PCT;
            r_bot_pct  <= bbf_pkg::RST_BOTTOM_PCT;
            r_side_pct <= bbf_pkg::RST_SIDE_PCT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bbf_pkg::CFG_IMAGE_WIDTH:    r_width    <= i_cfg_data;
                bbf_pkg::CFG_IMAGE_HEIGHT:   r_height   <= i_cfg_data;
                bbf_pkg::CFG_DARK_THRESHOLD: r_thr      <= i_cfg_data[bbf_pkg::THR_W-1:0];
                bbf_pkg::CFG_TOP_PERCENT:    r_top_pct  <= i_cfg_data[bbf_pkg::PCT_W-1:0];
                bbf_pkg::CFG_BOTTOM_PERCENT: r_bot_pct  <= i_cfg_data[bbf_pkg::PCT_W-1:0];
                bbf_pkg::CFG_SIDE_PERCENT:   r_side_pct <= i_cfg_data[bbf_pkg::PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Percent thresholds, one multiplier each, registered.
    always_ff @(posedge i_clk) begin
        r_top_need  <= bbf_pkg::t_prod'(r_top_pct)  * bbf_pkg::t_prod'(w_c);
        r_bot_need  <= bbf_pkg::t_prod'(r_bot_pct)  * bbf_pkg::t_prod'(w_c);
        r_side_need <= bbf_pkg::t_prod'(r_side_pct) * bbf_pkg::t_prod'(h_c);
    end

    // Input stage: handshake, hit test and position.
    assign s1_done  = r_s1_v && (!(r_s1_last_col && r_s1_last_row) || !r_out_v
                                 || o_bounds.ready);
    assign i_pix.ready = !r_s1_v || s1_done;
    assign accept   = i_pix.valid && i_pix.ready;
    assign pix_hit  = (i_pix.gray_pixel >= r_thr);
    assign last_col = ({1'b0, 12'(r_col)} + 13'd1) >= {1'b0, w_c};
    assign last_row = ({1'b0, 12'(r_row)} + 13'd1) >= {1'b0, h_c};
    assign hits_now = r_row_hits + bbf_pkg::t_count'(pix_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_row_hits <= '0;
            r_s1_v     <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v     <= 1'b1;
                r_row_hits <= last_col ? '0 : hits_now;
                r_col      <= last_col ? '0 : r_col + IW'(1);
                if (last_col) begin
                    r_row <= last_row ? '0 : r_row + RW'(1);
                end
            end else if (s1_done) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    // Count stage payload and memory read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_hit       <= pix_hit;
            r_s1_col       <= r_col;
            r_s1_row       <= r_row;
            r_s1_first_row <= (r_row == '0);
            r_s1_fstart    <= (r_row == '0) && (r_col == '0);
            r_s1_last_col  <= last_col;
            r_s1_last_row  <= last_row;
            r_s1_row_hits  <= hits_now;
            r_rd           <= mem_cols[r_col];
        end
    end

    // Column count update with bypass of the previous write.
    always_comb begin
        prev_cnt = (r_wr_v && (r_wr_col == r_s1_col)) ? r_wr_data : r_rd;
        cnt      = r_s1_first_row ? bbf_pkg::t_count'(r_s1_hit)
                                  : prev_cnt + bbf_pkg::t_count'(r_s1_hit);
        side_ok  = r_s1_last_row &&
                   ((bbf_pkg::t_prod'(cnt) * bbf_pkg::PCT_SCALE) >= r_side_need);
        top_ok   = (bbf_pkg::t_prod'(r_s1_row_hits) * bbf_pkg::PCT_SCALE) >= r_top_need;
        bot_ok   = (bbf_pkg::t_prod'(r_s1_row_hits) * bbf_pkg::PCT_SCALE) >= r_bot_need;
    end

    // Next bound values; the first pixel of a frame starts from defaults.
    always_comb begin
        if (r_s1_fstart) begin
            n_top        = '0;
            n_top_found  = 1'b0;
            n_bot        = h_c;
            n_left       = '0;
            n_left_found = 1'b0;
            n_right      = w_c;
        end else begin
            n_top        = r_top;
            n_top_found  = r_top_found;
            n_bot        = r_bot;
            n_left       = r_left;
            n_left_found = r_left_found;
            n_right      = r_right;
        end
        if (side_ok) begin
            if (!n_left_found) begin
                n_left       = 12'(r_s1_col);
                n_left_found = 1'b1;
            end
            n_right = 12'(r_s1_col);
        end
        if (r_s1_last_col) begin
            if (!n_top_found && top_ok) begin
                n_top       = 12'(r_s1_row);
                n_top_found = 1'b1;
            end
            if (bot_ok) begin
                n_bot = 12'(r_s1_row);
            end
        end
    end

    // Memory write.
    always_ff @(posedge i_clk) begin
        if (s1_done) begin
            mem_cols[r_s1_col] <= cnt;
        end
    end

    // Bypass register and bound state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_v       <= 1'b0;
            r_top        <= '0;
            r_top_found  <= 1'b0;
            r_bot        <= bbf_pkg::RST_HEIGHT;
            r_left       <= '0;
            r_left_found <= 1'b0;
            r_right      <= bbf_pkg::RST_WIDTH;
        end else if (s1_done) begin
            r_wr_v       <= 1'b1;
            r_top        <= n_top;
            r_top_found  <= n_top_found;
            r_bot        <= n_bot;
            r_left       <= n_left;
            r_left_found <= n_left_found;
            r_right      <= n_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done) begin
            r_wr_col  <= r_s1_col;
            r_wr_data <= cnt;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_done && r_s1_last_col && r_s1_last_row) begin
            r_out_v <= 1'b1;
        end else if (o_bounds.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done && r_s1_last_col && r_s1_last_row) begin
            r_out_top   <= n_top;
            r_out_bot   <= n_bot;
            r_out_left  <= n_left;
            r_out_right <= n_right;
        end
    end

    assign o_bounds.valid      = r_out_v;
    assign o_bounds.top_row    = r_out_top;
    assign o_bounds.bottom_row = r_out_bot;
    assign o_bounds.left_col   = r_out_left;
    assign o_bounds.right_col  = r_out_right;
    assign o_bounds.all_black  = (r_out_top > r_out_bot) || (r_out_right < r_out_left);

endmodule

// ===== rtl/bbf_checker.sv =====
`timescale 1ns / 1ps
`include "black_border_bounds_finder_unit_assert.svh"

// Port-level checks on the result channel of the bounds finder.
module bbf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input bbf_pkg::t_size i_top_row,
    input bbf_pkg::t_size i_bottom_row,
    input bbf_pkg::t_size i_left_col,
    input bbf_pkg::t_size i_right_col,
    input logic           i_all_black
);

    // A stalled result keeps its bounds.
    `BBF_ASSERT_RST(a_hold_stalled, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_top_row) && $stable(i_bottom_row) && $stable(i_left_col) && $stable(i_right_col), "stalled result changed")

    // The flag agrees with the bounds it is sent with.
    `BBF_ASSERT_RST(a_flag_match, i_clk, i_rst_n, i_out_valid |-> (i_all_black == ((i_top_row > i_bottom_row) || (i_right_col < i_left_col))), "all_black disagrees with bounds")

    // Reset empties the result register.
    `BBF_ASSERT(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind black_border_bounds_finder_unit bbf_checker u_bbf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_bounds.valid),
    .i_out_ready  (o_bounds.ready),
    .i_top_row    (o_bounds.top_row),
    .i_bottom_row (o_bounds.bottom_row),
    .i_left_col   (o_bounds.left_col),
    .i_right_col  (o_bounds.right_col),
    .i_all_black  (o_bounds.all_black)
);

// ===== test/tb_black_border_bounds_finder_unit.sv =====
`timescale 1ns / 1ps

module tb_black_border_bounds_finder_unit;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    // Pixels in the random part and the run limit in clock cycles.
    localparam int RANDOM_ITEMS  = 1350;
    localparam int CYCLE_LIMIT   = 400000;
    // Idle margin after every pending result has been taken.
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_PERCENT  = 16;
    // Indexes the block decodes to no register.
    localparam bbf_pkg::t_cfg_idx CFG_SPARE_LO = 3'd6;
    localparam bbf_pkg::t_cfg_idx CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        bbf_pkg::t_size top_row;
        bbf_pkg::t_size bottom_row;
        bbf_pkg::t_size left_col;
        bbf_pkg::t_size right_col;
        logic           all_black;
    } t_bounds;

    typedef enum int {FRAME_BOXED, FRAME_NOISE, FRAME_DARK, FRAME_LIT} t_frame_kind;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    bbf_pkg::t_cfg_idx i_cfg_idx;
    bbf_pkg::t_size    i_cfg_data;

    bbf_pix_if    pix_ch ();
    bbf_bounds_if bnd_ch ();

    black_border_bounds_finder_unit #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_pix     (pix_ch),
        .o_bounds  (bnd_ch)
    );

    // Shadow copy of the configuration registers.
    bbf_pkg::t_size cfg_width;
    bbf_pkg::t_size cfg_height;
    bbf_pkg::t_thr  cfg_thr;
    bbf_pkg::t_pct  cfg_top_pct;
    bbf_pkg::t_pct  cfg_bottom_pct;
    bbf_pkg::t_pct  cfg_side_pct;

    // Frame scan state of the bounds predictor.
    int unsigned col_hits [MAX_WIDTH];
    int unsigned row_pos;
    int unsigned col_pos;
    int unsigned row_hits;
    int unsigned top_b;
    int unsigned bottom_b;
    int unsigned left_b;
    int unsigned right_b;
    bit          top_seen;
    bit          left_seen;

    t_bounds     pending_bounds [$];
    int unsigned failures = 0;
    int unsigned pixels_sent = 0;
    int unsigned cycle_count = 0;
    bit          burst_mode = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Sizes of zero act as one and sizes above the maximum act as the maximum.
    function automatic int unsigned effective_size(input bbf_pkg::t_size v,
                                                   input int unsigned maxv);
        if (v == '0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic bit meets_share(input int unsigned count, input int unsigned pct,
                                       input int unsigned size);
        return count * 100 >= pct * size;
    endfunction

    task automatic reset_model();
        cfg_width      = bbf_pkg::RST_WIDTH;
        cfg_height     = bbf_pkg::RST_HEIGHT;
        cfg_thr        = bbf_pkg::RST_THRESHOLD;
        cfg_top_pct    = bbf_pkg::RST_TOP_PCT;
        cfg_bottom_pct = bbf_pkg::RST_BOTTOM_PCT;
        cfg_side_pct   = bbf_pkg::RST_SIDE_PCT;
        row_pos   = 0;
        col_pos   = 0;
        row_hits  = 0;
        top_b     = 0;
        top_seen  = 1'b0;
        bottom_b  = bbf_pkg::RST_HEIGHT;
        left_b    = 0;
        left_seen = 1'b0;
        right_b   = bbf_pkg::RST_WIDTH;
    endtask

    // Advances the frame scan by one pixel and queues the bounds at frame end.
    task automatic accumulate_pixel(input bbf_pkg::t_thr pix);
        int unsigned w;
        int unsigned h;
        int unsigned hit;
        int unsigned cnt;
        bit          last_col;
        bit          last_row;
        t_bounds     res;
        w = effective_size(cfg_width, MAX_WIDTH);
        h = effective_size(cfg_height, MAX_HEIGHT);
        hit = (pix >= cfg_thr) ? 1 : 0;
        last_col = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);

        // The first pixel of a frame reloads the bounds.
        if (row_pos == 0 && col_pos == 0) begin
            top_b     = 0;
            top_seen  = 1'b0;
            bottom_b  = h;
            left_b    = 0;
            left_seen = 1'b0;
            right_b   = w;
            row_hits  = 0;
        end

        row_hits += hit;
        cnt = (row_pos == 0) ? hit : col_hits[col_pos] + hit;
        col_hits[col_pos] = cnt;

        // Column totals are complete only during the last row.
        if (last_row && meets_share(cnt, cfg_side_pct, h)) begin
            if (!left_seen) begin
                left_b    = col_pos;
                left_seen = 1'b1;
            end
            right_b = col_pos;
        end

        if (!last_col) begin
            col_pos++;
        end else begin
            if (!top_seen && meets_share(row_hits, cfg_top_pct, w)) begin
                top_b    = row_pos;
                top_seen = 1'b1;
            end
            if (meets_share(row_hits, cfg_bottom_pct, w)) begin
                bottom_b = row_pos;
            end
            row_hits = 0;
            col_pos  = 0;
            if (!last_row) begin
                row_pos++;
            end else begin
                row_pos = 0;
                res.top_row    = bbf_pkg::t_size'(top_b);
                res.bottom_row = bbf_pkg::t_size'(bottom_b);
                res.left_col   = bbf_pkg::t_size'(left_b);
                res.right_col  = bbf_pkg::t_size'(right_b);
                res.all_black  = (top_b > bottom_b) || (right_b < left_b);
                pending_bounds = {pending_bounds, res};
            end
        end
    endtask

    task automatic check_field(input string name, input bbf_pkg::t_size expv,
                               input bbf_pkg::t_size actv);
        if (actv !== expv) begin
            $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
            failures++;
        end
    endtask

    // Accepted pixels feed the predictor; accepted results are checked in order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_ch.valid && pix_ch.ready) begin
                accumulate_pixel(pix_ch.gray_pixel);
            end
            if (bnd_ch.valid && bnd_ch.ready) begin
                if (pending_bounds.size() == 0) begin
                    $error("bounds request arrived with no frame pending");
                    failures++;
                end else begin
                    check_field("top_row", pending_bounds[0].top_row, bnd_ch.top_row);
                    check_field("bottom_row", pending_bounds[0].bottom_row,
                                bnd_ch.bottom_row);
                    check_field("left_col", pending_bounds[0].left_col, bnd_ch.left_col);
                    check_field("right_col", pending_bounds[0].right_col, bnd_ch.right_col);
                    check_field("all_black", bbf_pkg::t_size'(pending_bounds[0].all_black),
                                bbf_pkg::t_size'(bnd_ch.all_black));
                    void'(pending_bounds.pop_front());
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The receiver stalls at random except during burst stretches.
    initial begin
        bnd_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            bnd_ch.ready <= burst_mode || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Every driving task is entered and left at a falling edge.
    task automatic send_pixel(input bbf_pkg::t_thr pix);
        while (!burst_mode && $urandom_range(99) < IDLE_PERCENT) begin
            pix_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.gray_pixel <= pix;
        do @(posedge i_clk); while (!(pix_ch.valid && pix_ch.ready));
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // Stops the pixel stream and waits for every pending result.
    task automatic settle_block();
        pix_ch.valid <= 1'b0;
        while (pending_bounds.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input bbf_pkg::t_cfg_idx idx, input bbf_pkg::t_size data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            bbf_pkg::CFG_IMAGE_WIDTH:    cfg_width      = data;
            bbf_pkg::CFG_IMAGE_HEIGHT:   cfg_height     = data;
            bbf_pkg::CFG_DARK_THRESHOLD: cfg_thr        = data[bbf_pkg::THR_W-1:0];
            bbf_pkg::CFG_TOP_PERCENT:    cfg_top_pct    = data[bbf_pkg::PCT_W-1:0];
            bbf_pkg::CFG_BOTTOM_PERCENT: cfg_bottom_pct = data[bbf_pkg::PCT_W-1:0];
            bbf_pkg::CFG_SIDE_PERCENT:   cfg_side_pct   = data[bbf_pkg::PCT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Levels that count as content, with the threshold itself often.
    function automatic bbf_pkg::t_thr content_level();
        if ($urandom_range(3) == 0) return cfg_thr;
        return bbf_pkg::t_thr'($urandom_range(255, cfg_thr));
    endfunction

    // Levels below the threshold; with a threshold of zero every level is content.
    function automatic bbf_pkg::t_thr dark_level();
        if (cfg_thr == '0) return '0;
        if ($urandom_range(3) == 0) return cfg_thr - 1'b1;
        return bbf_pkg::t_thr'($urandom_range(cfg_thr - 1, 0));
    endfunction

    // One frame at the current size: a content box in a dark border, noise,
    // or a uniform frame.
    task automatic send_frame(input t_frame_kind kind);
        int unsigned w;
        int unsigned h;
        int unsigned r0;
        int unsigned r1;
        int unsigned c0;
        int unsigned c1;
        bit          lit;
        w  = effective_size(cfg_width, MAX_WIDTH);
        h  = effective_size(cfg_height, MAX_HEIGHT);
        r0 = $urandom_range(h - 1, 0);
        r1 = $urandom_range(h - 1, r0);
        c0 = $urandom_range(w - 1, 0);
        c1 = $urandom_range(w - 1, c0);
        for (int unsigned r = 0; r < h; r++) begin
            for (int unsigned c = 0; c < w; c++) begin
                case (kind)
                    FRAME_NOISE: send_pixel(bbf_pkg::t_thr'($urandom));
                    FRAME_DARK:  send_pixel(dark_level());
                    FRAME_LIT:   send_pixel(content_level());
                    default: begin
                        lit = (r >= r0) && (r <= r1) && (c >= c0) && (c <= c1);
                        if ($urandom_range(9) == 0) lit = !lit;
                        send_pixel(lit ? content_level() : dark_level());
                    end
                endcase
            end
        end
    endtask

    function automatic bbf_pkg::t_size pick_size(input bit allow_large);
        case ($urandom_range(9))
            0: return '0;
            1: return 12'd1;
            2: return allow_large ? bbf_pkg::t_size'($urandom_range(40, 13)) : 12'd3;
            default: return bbf_pkg::t_size'($urandom_range(12, 2));
        endcase
    endfunction

    function automatic bbf_pkg::t_pct pick_percent();
        case ($urandom_range(9))
            0: return '0;
            1: return 7'd100;
            2: return bbf_pkg::t_pct'($urandom_range(127, 101));
            default: return bbf_pkg::t_pct'($urandom_range(99, 1));
        endcase
    endfunction

    function automatic bbf_pkg::t_thr pick_threshold();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return bbf_pkg::t_thr'($urandom_range(254, 1));
        endcase
    endfunction

    function automatic t_frame_kind pick_kind();
        case ($urandom_range(9))
            0: return FRAME_NOISE;
            1: return FRAME_DARK;
            2: return FRAME_LIT;
            default: return FRAME_BOXED;
        endcase
    endfunction

    // Writes every register with a random setting; unused upper data bits are noise.
    task automatic apply_random_settings();
        bbf_pkg::t_size w;
        bbf_pkg::t_size h;
        w = pick_size(1'b1);
        h = (w > 12) ? bbf_pkg::t_size'($urandom_range(3, 0)) : pick_size(1'b1);
        write_reg(bbf_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(bbf_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(bbf_pkg::CFG_DARK_THRESHOLD, {4'($urandom), pick_threshold()});
        write_reg(bbf_pkg::CFG_TOP_PERCENT, {5'($urandom), pick_percent()});
        write_reg(bbf_pkg::CFG_BOTTOM_PERCENT, {5'($urandom), pick_percent()});
        write_reg(bbf_pkg::CFG_SIDE_PERCENT, {5'($urandom), pick_percent()});
    endtask

    // Default threshold and percents on a small frame, pixels around the threshold.
    task automatic test_default_registers();
        bbf_pkg::t_thr pattern [12] = '{8'd10, 8'd10, 8'd10, 8'd9,
                                        8'd255, 8'd0, 8'd9, 8'd10,
                                        8'd200, 8'd11, 8'd12, 8'd13};
        settle_block();
        write_reg(bbf_pkg::CFG_IMAGE_WIDTH, 12'd4);
        write_reg(bbf_pkg::CFG_IMAGE_HEIGHT, 12'd3);
        foreach (pattern[i]) send_pixel(pattern[i]);
    endtask

    // One-pixel frames at the threshold extremes.
    task automatic test_single_pixel_frames();
        settle_block();
        write_reg(bbf_pkg::CFG_IMAGE_WIDTH, 12'd1);
        write_reg(bbf_pkg::CFG_IMAGE_HEIGHT, 12'd1);
        send_pixel(8'd0);
        send_pixel(8'd255);
        settle_block();
        write_reg(bbf_pkg::CFG_DARK_THRESHOLD, 12'd255);
        send_pixel(8'd255);
        send_pixel(8'd254);
        settle_block();
        write_reg(bbf_pkg::CFG_DARK_THRESHOLD, 12'd0);
        send_pixel(8'd0);
    endtask

    // A zero percent lets every row and column qualify; above 100 none can.
    task automatic test_percent_extremes();
        settle_block();
        write_reg(bbf_pkg::CFG_IMAGE_WIDTH, 12'd3);
        write_reg(bbf_pkg::CFG_IMAGE_HEIGHT, 12'd2);
        write_reg(bbf_pkg::CFG_DARK_THRESHOLD, 12'd128);
        write_reg(bbf_pkg::CFG_TOP_PERCENT, 12'd0);
        write_reg(bbf_pkg::CFG_BOTTOM_PERCENT, 12'd0);
        write_reg(bbf_pkg::CFG_SIDE_PERCENT, 12'd0);
        send_frame(FRAME_DARK);
        settle_block();
        write_reg(bbf_pkg::CFG_TOP_PERCENT, 12'd127);
        write_reg(bbf_pkg::CFG_BOTTOM_PERCENT, 12'd101);
        write_reg(bbf_pkg::CFG_SIDE_PERCENT, 12'd100);
        send_frame(FRAME_LIT);
    endtask

    // Writes to undecoded indexes leave the settings alone.
    task automatic test_unused_register_indexes();
        settle_block();
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '1);
        write_reg(bbf_pkg::CFG_IMAGE_WIDTH, 12'd2);
        write_reg(bbf_pkg::CFG_IMAGE_HEIGHT, 12'd2);
        send_frame(FRAME_NOISE);
    endtask

    // Sizes of zero act as one, in either dimension or both.
    task automatic test_size_limits();
        settle_block();
        write_reg(bbf_pkg::CFG_DARK_THRESHOLD, 12'd100);
        write_reg(bbf_pkg::CFG_TOP_PERCENT, 12'd50);
        write_reg(bbf_pkg::CFG_BOTTOM_PERCENT, 12'd50);
        write_reg(bbf_pkg::CFG_SIDE_PERCENT, 12'd50);
        write_reg(bbf_pkg::CFG_IMAGE_WIDTH, 12'd9);
        write_reg(bbf_pkg::CFG_IMAGE_HEIGHT, 12'd0);
        send_frame(FRAME_NOISE);
        settle_block();
        write_reg(bbf_pkg::CFG_IMAGE_WIDTH, 12'd0);
        write_reg(bbf_pkg::CFG_IMAGE_HEIGHT, 12'd7);
        send_frame(FRAME_NOISE);
        settle_block();
        write_reg(bbf_pkg::CFG_IMAGE_WIDTH, 12'd0);
        write_reg(bbf_pkg::CFG_IMAGE_HEIGHT, 12'd0);
        send_frame(FRAME_BOXED);
    endtask

    // The sender holds off after each frame until its result has been taken.
    task automatic test_drained_frames();
        settle_block();
        write_reg(bbf_pkg::CFG_IMAGE_WIDTH, 12'd6);
        write_reg(bbf_pkg::CFG_IMAGE_HEIGHT, 12'd3);
        write_reg(bbf_pkg::CFG_DARK_THRESHOLD, 12'd64);
        write_reg(bbf_pkg::CFG_TOP_PERCENT, 12'd65);
        write_reg(bbf_pkg::CFG_BOTTOM_PERCENT, 12'd85);
        write_reg(bbf_pkg::CFG_SIDE_PERCENT, 12'd80);
        repeat (5) begin
            send_frame(FRAME_BOXED);
            settle_block();
        end
    endtask

    // Phases of random settings, each with a few back-to-back frames; some
    // phases run as long bursts with neither side idling.
    task automatic test_random_frames();
        int unsigned start;
        int unsigned phase;
        int unsigned phase_start;
        int unsigned frames;
        start = pixels_sent;
        phase = 0;
        while (pixels_sent - start < RANDOM_ITEMS) begin
            settle_block();
            apply_random_settings();
            burst_mode  = (phase % 6 == 2);
            phase_start = pixels_sent;
            frames      = $urandom_range(4, 1);
            while (frames != 0 || (burst_mode && pixels_sent - phase_start < 250)) begin
                send_frame(pick_kind());
                if (frames != 0) frames--;
            end
            burst_mode = 1'b0;
            phase++;
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = bbf_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data        = '0;
        pix_ch.valid      = 1'b0;
        pix_ch.gray_pixel = '0;
        reset_model();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_registers();
        test_single_pixel_frames();
        test_percent_extremes();
        test_unused_register_indexes();
        test_size_limits();
        test_drained_frames();
        test_random_frames();

        settle_block();
        repeat (20) @(posedge i_clk);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bbf_pkg.sv
rtl/bbf_if.sv
rtl/black_border_bounds_finder_unit.sv
rtl/bbf_checker.sv
test/tb_black_border_bounds_finder_unit.sv
